FILE: hdl/eck_pkg.sv
// Shared types, constants and operation codes for the enzyme complex kinetics block.
// Used by the channel interfaces, the arithmetic unit, the sequencer and the top level.
// No dependencies.
`default_nettype none

package eck_pkg;

  localparam int FracBits    = 24;
  localparam int DataW       = 48;
  localparam int ExpBits     = 48;
  localparam int TaylorTerms = 12;
  localparam int MaxSubst    = 2;
  // operand width of the shared unit: one spare bit for exp(-y) values up to 1.0
  localparam int MulW        = ExpBits + 1;
  localparam int CfgAddrW    = 6;
  localparam int CfgDataW    = 64;

  localparam logic [DataW-1:0] VMax     = '1;
  localparam logic [DataW-1:0] QOne     = DataW'(1) << FracBits;
  localparam logic [DataW-1:0] ExpLimit = DataW'(44) << FracBits;

  // complex_mode codes
  localparam logic [1:0] ModeMassAction = 2'd0;
  localparam logic [1:0] ModeMm         = 2'd1;
  localparam logic [1:0] ModeLegacy     = 2'd2;

  // register indexes (paddr[5:3])
  localparam logic [2:0] RegRateBind      = 3'd0;
  localparam logic [2:0] RegRateUnbind    = 3'd1;
  localparam logic [2:0] RegRateCatalysis = 3'd2;
  localparam logic [2:0] RegTimeStep      = 3'd3;
  localparam logic [2:0] RegComplexMode   = 3'd4;
  localparam logic [2:0] RegInitComplex   = 3'd5;

  typedef enum logic [1:0] {
    OP_QMUL,  // (a*b) >> FracBits, saturating
    OP_EMUL,  // (a*b) >> ExpBits
    OP_QDIV,  // (a << FracBits) / b, saturating, /0 gives max
    OP_IDIV   // a / b, integer
  } alu_op_e;

  typedef struct packed {
    logic            start;
    alu_op_e         op;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic            done;
    logic [MulW-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [DataW-1:0] rate_bind;
    logic [DataW-1:0] rate_unbind;
    logic [DataW-1:0] rate_catalysis;
    logic [DataW-1:0] time_step;
    logic [1:0]       complex_mode;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/eck_in_if.sv
// Input channel: one simulation tick per transaction, valid/ready handshake.
// Depends on eck_pkg.
`default_nettype none

interface eck_in_if;
  logic                      valid;
  logic                      ready;
  logic [eck_pkg::DataW-1:0] enzyme_count;
  logic [eck_pkg::DataW-1:0] substrate_first;
  logic [eck_pkg::DataW-1:0] substrate_second;
  logic [1:0]                substrate_count;
  logic [eck_pkg::DataW-1:0] intramol_scale;
  logic [eck_pkg::DataW-1:0] volume;
  logic                      product_present;

  modport source (output valid, enzyme_count, substrate_first, substrate_second,
                  substrate_count, intramol_scale, volume, product_present,
                  input ready);
  modport sink (input valid, enzyme_count, substrate_first, substrate_second,
                substrate_count, intramol_scale, volume, product_present,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/eck_out_if.sv
// Result channel: fluxes and complex level per tick, valid/ready handshake.
// Depends on eck_pkg.
`default_nettype none

interface eck_out_if;
  logic                      valid;
  logic                      ready;
  logic [eck_pkg::DataW-1:0] unbind_flux;
  logic [eck_pkg::DataW-1:0] bind_flux;
  logic [eck_pkg::DataW-1:0] product_flux;
  logic [eck_pkg::DataW-1:0] release_flux;
  logic [eck_pkg::DataW-1:0] complex_level;
  logic [eck_pkg::DataW-1:0] complex_conc;

  modport source (output valid, unbind_flux, bind_flux, product_flux, release_flux,
                  complex_level, complex_conc, input ready);
  modport sink (input valid, unbind_flux, bind_flux, product_flux, release_flux,
                complex_level, complex_conc, output ready);
endinterface

`default_nettype wire

FILE: hdl/eck_alu.sv
// Shared iterative arithmetic unit: chunked multiplier and restoring divider.
// Depends on eck_pkg.
`default_nettype none

module eck_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eck_pkg::alu_req_t req_i,
  output eck_pkg::alu_rsp_t rsp_o
);

  localparam int ChunkW = 17;
  localparam int NChunk = (eck_pkg::MulW + ChunkW - 1) / ChunkW;
  localparam int BExtW  = NChunk * ChunkW;
  localparam int AccW   = eck_pkg::MulW + BExtW;
  localparam int PpW    = eck_pkg::MulW + ChunkW;
  localparam int DvdW   = eck_pkg::DataW + eck_pkg::FracBits;
  localparam int CntW   = $clog2(DvdW);
  localparam int MulW   = eck_pkg::MulW;
  localparam int DataW  = eck_pkg::DataW;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} alu_st_e;

  alu_st_e           state_q;
  eck_pkg::alu_op_e  op_q;
  logic [MulW-1:0]   a_q;
  logic [BExtW-1:0]  b_q;
  logic [AccW-1:0]   acc_q;
  logic [DvdW-1:0]   dvd_q;
  logic [DvdW-1:0]   quo_q;
  logic [MulW-1:0]   rem_q;
  logic [MulW-1:0]   dsr_q;
  logic [CntW-1:0]   cnt_q;
  logic [MulW-1:0]   res_q;
  logic              done_q;

  logic [ChunkW-1:0] chunk;
  logic [PpW-1:0]    pp;
  logic [AccW-1:0]   acc_nxt;
  logic [AccW-1:0]   qsh;
  logic [AccW-1:0]   esh;
  logic [MulW-1:0]   mul_res;
  logic [MulW:0]     part;
  logic              fits;
  logic [MulW:0]     diff;
  logic [MulW-1:0]   rem_nxt;
  logic [DvdW-1:0]   quo_nxt;
  logic [MulW-1:0]   div_res;

  // multiply: one chunk of b per cycle, most significant first
  assign chunk   = b_q[BExtW-1 -: ChunkW];
  assign pp      = PpW'(a_q) * PpW'(chunk);
  assign acc_nxt = (acc_q << ChunkW) + AccW'(pp);
  assign qsh     = acc_nxt >> eck_pkg::FracBits;
  assign esh     = acc_nxt >> eck_pkg::ExpBits;

  always_comb begin
    if (op_q == eck_pkg::OP_QMUL) begin
      mul_res = (|qsh[AccW-1:DataW]) ? {1'b0, eck_pkg::VMax} : {1'b0, qsh[DataW-1:0]};
    end else begin
      mul_res = esh[MulW-1:0];
    end
  end

  // divide: one quotient bit per cycle
  assign part    = {rem_q, dvd_q[DvdW-1]};
  assign fits    = part >= {1'b0, dsr_q};
  assign diff    = part - {1'b0, dsr_q};
  assign rem_nxt = fits ? diff[MulW-1:0] : part[MulW-1:0];
  assign quo_nxt = {quo_q[DvdW-2:0], fits};

  always_comb begin
    if (op_q == eck_pkg::OP_QDIV) begin
      div_res = (|quo_nxt[DvdW-1:DataW]) ? {1'b0, eck_pkg::VMax}
                                         : {1'b0, quo_nxt[DataW-1:0]};
    end else begin
      div_res = quo_nxt[MulW-1:0];
    end
  end

  // sequencing of the unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      op_q    <= eck_pkg::OP_QMUL;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            op_q <= req_i.op;
            if (req_i.op == eck_pkg::OP_QMUL || req_i.op == eck_pkg::OP_EMUL) begin
              a_q     <= req_i.a;
              b_q     <= BExtW'(req_i.b);
              acc_q   <= '0;
              cnt_q   <= CntW'(NChunk - 1);
              state_q <= ST_MUL;
            end else if (req_i.b == '0) begin
              res_q  <= {1'b0, eck_pkg::VMax};
              done_q <= 1'b1;
            end else begin
              rem_q <= '0;
              quo_q <= '0;
              dsr_q <= req_i.b;
              if (req_i.op == eck_pkg::OP_QDIV) begin
                dvd_q <= DvdW'(req_i.a[DataW-1:0]) << eck_pkg::FracBits;
                cnt_q <= CntW'(DvdW - 1);
              end else begin
                dvd_q <= {req_i.a, (DvdW - MulW)'(0)};
                cnt_q <= CntW'(MulW - 1);
              end
              state_q <= ST_DIV;
            end
          end
        end
        ST_MUL: begin
          acc_q <= acc_nxt;
          b_q   <= b_q << ChunkW;
          if (cnt_q == '0) begin
            res_q   <= mul_res;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIV: begin
          rem_q <= rem_nxt;
          quo_q <= quo_nxt;
          dvd_q <= dvd_q << 1;
          if (cnt_q == '0) begin
            res_q   <= div_res;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

`default_nettype wire

FILE: hdl/eck_seq.sv
// Tick sequencer: holds the complex and last fluxes, steps the shared unit
// through one tick and runs the handshakes. Depends on eck_pkg, eck_in_if, eck_out_if.
`default_nettype none

module eck_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eck_pkg::cfg_t     cfg_i,
  eck_in_if.sink            in_i,
  eck_out_if.source         out_o,
  output eck_pkg::alu_req_t alu_req_o,
  input  eck_pkg::alu_rsp_t alu_rsp_i
);

  localparam int DataW = eck_pkg::DataW;
  localparam int MulW  = eck_pkg::MulW;
  localparam int YW    = DataW + eck_pkg::ExpBits - eck_pkg::FracBits;
  localparam int KW    = $clog2(YW);
  localparam int TiW   = $clog2(eck_pkg::TaylorTerms + 1);
  localparam logic [YW-1:0] YLimit = YW'(1) << (eck_pkg::ExpBits - 4);
  localparam logic [MulW-1:0] SOne = MulW'(1) << eck_pkg::ExpBits;

  typedef enum logic [4:0] {
    S_IDLE, S_FE, S_SUB, S_PREP, S_KM, S_MMP1, S_MMP2, S_MMRATE, S_MMC,
    S_UNB, S_BP, S_BND, S_CAT, S_RDT, S_X, S_HALVE, S_TMUL, S_TDIV, S_SQ,
    S_RATIO, S_FAC, S_CEXP, S_FWD, S_CONC, S_OUT
  } seq_st_e;

  function automatic logic [DataW-1:0] qadd(input logic [DataW-1:0] a,
                                            input logic [DataW-1:0] b);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DataW] ? eck_pkg::VMax : s[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] satsub(input logic [DataW-1:0] a,
                                              input logic [DataW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  seq_st_e          state_q;
  logic             issued_q;
  logic             out_valid_q;
  // latched tick inputs
  logic [DataW-1:0] enz_q, s1_q, s2_q, scale_q, vol_q;
  logic             two_sub_q;
  // state of the model
  logic [DataW-1:0] c_q, unb_q, bnd_q, cat_q, rel_q;
  // working registers
  logic [DataW-1:0] fe_q, te_q, subs_q, km_q, tmp_q, d_q, conc_q;
  logic [YW-1:0]    y_q;
  logic [KW-1:0]    k_q;
  logic [TiW-1:0]   ti_q;
  logic [MulW-1:0]  t_q, s_q;

  logic             op_state;
  logic [DataW-1:0] res48;
  logic [DataW-1:0] rel_new;
  logic [DataW-1:0] c_cand;
  logic [DataW-1:0] c_capped;
  logic [MulW-1:0]  s_next;
  logic             tick_active;

  assign res48       = alu_rsp_i.res[DataW-1:0];
  assign rel_new     = qadd(res48, unb_q);
  assign tick_active = (in_i.substrate_count != 2'd0) && in_i.product_present;

  // next complex: exponential result, or forward Euler step, then legacy cap
  always_comb begin
    if (state_q == S_CEXP) begin
      c_cand = res48;
    end else if (bnd_q >= rel_q) begin
      c_cand = qadd(c_q, res48);
    end else begin
      c_cand = satsub(c_q, res48);
    end
    c_capped = (cfg_i.complex_mode == eck_pkg::ModeLegacy && c_cand > te_q) ? te_q : c_cand;
  end

  // Taylor accumulation: odd terms subtract, even terms add
  always_comb begin
    if (ti_q[0]) begin
      s_next = (s_q > alu_rsp_i.res) ? s_q - alu_rsp_i.res : '0;
    end else begin
      s_next = s_q + alu_rsp_i.res;
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req_o.op = eck_pkg::OP_QMUL;
    alu_req_o.a  = '0;
    alu_req_o.b  = '0;
    op_state     = 1'b1;
    unique case (state_q)
      S_FE: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, enz_q};
        alu_req_o.b  = {1'b0, scale_q};
      end
      S_SUB: begin
        alu_req_o.a = {1'b0, s1_q};
        alu_req_o.b = {1'b0, s2_q};
        op_state    = two_sub_q;
      end
      S_KM: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, qadd(cfg_i.rate_unbind, cfg_i.rate_catalysis)};
        alu_req_o.b  = {1'b0, cfg_i.rate_bind};
      end
      S_MMP1, S_BP: begin
        alu_req_o.a = {1'b0, subs_q};
        alu_req_o.b = {1'b0, fe_q};
      end
      S_MMP2: begin
        alu_req_o.a = {1'b0, tmp_q};
        alu_req_o.b = {1'b0, cfg_i.rate_catalysis};
      end
      S_MMRATE: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, tmp_q};
        alu_req_o.b  = {1'b0, qadd(subs_q, km_q)};
      end
      S_MMC: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, bnd_q};
        alu_req_o.b  = {1'b0, cfg_i.rate_catalysis};
      end
      S_UNB: begin
        alu_req_o.a = {1'b0, cfg_i.rate_unbind};
        alu_req_o.b = {1'b0, c_q};
      end
      S_BND: begin
        alu_req_o.a = {1'b0, tmp_q};
        alu_req_o.b = {1'b0, cfg_i.rate_bind};
      end
      S_CAT: begin
        alu_req_o.a = {1'b0, cfg_i.rate_catalysis};
        alu_req_o.b = {1'b0, c_q};
      end
      S_RDT: begin
        alu_req_o.a = {1'b0, rel_q};
        alu_req_o.b = {1'b0, cfg_i.time_step};
      end
      S_X: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, tmp_q};
        alu_req_o.b  = {1'b0, c_q};
      end
      S_TMUL: begin
        alu_req_o.op = eck_pkg::OP_EMUL;
        alu_req_o.a  = t_q;
        alu_req_o.b  = y_q[MulW-1:0];
      end
      S_TDIV: begin
        alu_req_o.op = eck_pkg::OP_IDIV;
        alu_req_o.a  = t_q;
        alu_req_o.b  = MulW'(ti_q);
      end
      S_SQ: begin
        alu_req_o.op = eck_pkg::OP_EMUL;
        alu_req_o.a  = s_q;
        alu_req_o.b  = s_q;
      end
      S_RATIO: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, bnd_q};
        alu_req_o.b  = {1'b0, rel_q};
      end
      S_FAC: begin
        alu_req_o.a = {1'b0, tmp_q};
        alu_req_o.b = {1'b0, eck_pkg::QOne - d_q};
      end
      S_CEXP: begin
        alu_req_o.a = {1'b0, c_q};
        alu_req_o.b = {1'b0, tmp_q};
      end
      S_FWD: begin
        alu_req_o.a = {1'b0, (bnd_q >= rel_q) ? bnd_q - rel_q : rel_q - bnd_q};
        alu_req_o.b = {1'b0, cfg_i.time_step};
      end
      S_CONC: begin
        alu_req_o.op = eck_pkg::OP_QDIV;
        alu_req_o.a  = {1'b0, c_q};
        alu_req_o.b  = {1'b0, vol_q};
      end
      default: op_state = 1'b0;
    endcase
    alu_req_o.start = op_state && !issued_q;
  end

  // sequencer: state, model state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      c_q         <= '0;
      unb_q       <= '0;
      bnd_q       <= '0;
      cat_q       <= '0;
      rel_q       <= '0;
    end else begin
      if (alu_req_o.start) begin
        issued_q <= 1'b1;
      end
      if (alu_rsp_i.done) begin
        issued_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            enz_q     <= in_i.enzyme_count;
            s1_q      <= in_i.substrate_first;
            s2_q      <= in_i.substrate_second;
            two_sub_q <= in_i.substrate_count[1] && (eck_pkg::MaxSubst >= 2);
            scale_q   <= in_i.intramol_scale;
            vol_q     <= in_i.volume;
            fe_q      <= in_i.enzyme_count;
            if (!tick_active) begin
              state_q <= S_CONC;
            end else if (in_i.intramol_scale != '0) begin
              state_q <= S_FE;
            end else begin
              state_q <= S_SUB;
            end
          end
        end
        S_FE: if (alu_rsp_i.done) begin
          fe_q    <= res48;
          state_q <= S_SUB;
        end
        S_SUB: begin
          if (!two_sub_q) begin
            subs_q  <= s1_q;
            state_q <= S_PREP;
          end else if (alu_rsp_i.done) begin
            subs_q  <= res48;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          te_q <= fe_q;
          if (cfg_i.complex_mode == eck_pkg::ModeMm) begin
            state_q <= S_KM;
          end else begin
            if (cfg_i.complex_mode == eck_pkg::ModeLegacy) begin
              fe_q <= satsub(fe_q, c_q);
            end
            state_q <= S_UNB;
          end
        end
        S_KM: if (alu_rsp_i.done) begin
          km_q    <= res48;
          state_q <= S_MMP1;
        end
        S_MMP1: if (alu_rsp_i.done) begin
          tmp_q   <= res48;
          state_q <= S_MMP2;
        end
        S_MMP2: if (alu_rsp_i.done) begin
          tmp_q   <= res48;
          state_q <= S_MMRATE;
        end
        S_MMRATE: if (alu_rsp_i.done) begin
          unb_q   <= '0;
          bnd_q   <= res48;
          cat_q   <= res48;
          rel_q   <= '0;
          state_q <= S_MMC;
        end
        S_MMC: if (alu_rsp_i.done) begin
          c_q     <= res48;
          state_q <= S_CONC;
        end
        S_UNB: if (alu_rsp_i.done) begin
          unb_q   <= res48;
          state_q <= S_BP;
        end
        S_BP: if (alu_rsp_i.done) begin
          tmp_q   <= res48;
          state_q <= S_BND;
        end
        S_BND: if (alu_rsp_i.done) begin
          bnd_q   <= res48;
          state_q <= S_CAT;
        end
        S_CAT: if (alu_rsp_i.done) begin
          cat_q   <= res48;
          rel_q   <= rel_new;
          state_q <= (c_q != '0 && rel_new != '0) ? S_RDT : S_FWD;
        end
        S_RDT: if (alu_rsp_i.done) begin
          tmp_q   <= res48;
          state_q <= S_X;
        end
        S_X: if (alu_rsp_i.done) begin
          if (res48 >= eck_pkg::ExpLimit) begin
            d_q     <= '0;
            state_q <= S_RATIO;
          end else begin
            y_q     <= YW'(res48) << (eck_pkg::ExpBits - eck_pkg::FracBits);
            k_q     <= '0;
            state_q <= S_HALVE;
          end
        end
        // range reduction: halve y until it is at most 1/16
        S_HALVE: begin
          if (y_q > YLimit) begin
            y_q <= y_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            t_q     <= SOne;
            s_q     <= SOne;
            ti_q    <= TiW'(1);
            state_q <= S_TMUL;
          end
        end
        S_TMUL: if (alu_rsp_i.done) begin
          t_q     <= alu_rsp_i.res;
          state_q <= S_TDIV;
        end
        S_TDIV: if (alu_rsp_i.done) begin
          t_q <= alu_rsp_i.res;
          s_q <= s_next;
          if (ti_q == TiW'(eck_pkg::TaylorTerms)) begin
            if (k_q == '0) begin
              d_q     <= DataW'(s_next >> (eck_pkg::ExpBits - eck_pkg::FracBits));
              state_q <= S_RATIO;
            end else begin
              state_q <= S_SQ;
            end
          end else begin
            ti_q    <= ti_q + 1'b1;
            state_q <= S_TMUL;
          end
        end
        // undo the range reduction by repeated squaring
        S_SQ: if (alu_rsp_i.done) begin
          s_q <= alu_rsp_i.res;
          k_q <= k_q - 1'b1;
          if (k_q == KW'(1)) begin
            d_q     <= DataW'(alu_rsp_i.res >> (eck_pkg::ExpBits - eck_pkg::FracBits));
            state_q <= S_RATIO;
          end
        end
        S_RATIO: if (alu_rsp_i.done) begin
          tmp_q   <= res48;
          state_q <= S_FAC;
        end
        S_FAC: if (alu_rsp_i.done) begin
          tmp_q   <= qadd(d_q, res48);
          state_q <= S_CEXP;
        end
        S_CEXP, S_FWD: if (alu_rsp_i.done) begin
          c_q     <= c_capped;
          state_q <= S_CONC;
        end
        S_CONC: if (alu_rsp_i.done) begin
          conc_q      <= res48;
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: if (out_o.ready) begin
          out_valid_q <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.unbind_flux   = unb_q;
  assign out_o.bind_flux     = bnd_q;
  assign out_o.product_flux  = cat_q;
  assign out_o.release_flux  = rel_q;
  assign out_o.complex_level = c_q;
  assign out_o.complex_conc  = conc_q;

  // a pending result blocks new input
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a result is pending");

  // one tick at a time
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready held after input transaction");

  // the unit only answers an outstanding request
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp_i.done |-> issued_q)
    else $error("unit response without request");

endmodule

`default_nettype wire

FILE: hdl/enzyme_complex_kinetics_step_top.sv
// Top level: configuration registers on the APB port, sequencer and shared unit.
// Depends on eck_pkg, eck_in_if, eck_out_if, eck_alu, eck_seq.
`default_nettype none

// One input transaction is one simulation tick; the block returns exactly one
// result per tick and takes one tick at a time. All multiplies and divides run
// through a single shared unit: a multiply is a start, three 17-bit chunk steps
// and a handoff, a Q24.24 divide a start, one quotient bit per cycle over 72
// bits and a handoff, and a Taylor-term integer divide the same over 49 bits.
// An idle tick (no substrate or no product pool) costs one divide. A mass-action
// tick ends in a forward Euler step or in the exponential update, which runs
// the twelve Taylor divides and the squaring steps. Registers: k1 at 0x00, k2
// 0x08, k3 0x10, dt 0x18, mode 0x20, initial complex 0x28; all are 64-bit
// accesses. The initial complex register is only stored and read back; the
// complex resets to zero.
module enzyme_complex_kinetics_step_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eck_pkg::CfgAddrW-1:0]   paddr,
  input  logic [eck_pkg::CfgDataW-1:0]   pwdata,
  output logic [eck_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  eck_in_if.sink                         in_i,
  eck_out_if.source                      out_o
);

  localparam int DataW = eck_pkg::DataW;

  logic [DataW-1:0] rate_bind_q, rate_unbind_q, rate_catalysis_q, time_step_q;
  logic [DataW-1:0] init_complex_q;
  logic [1:0]       mode_q;
  logic [2:0]       reg_idx;
  logic             wr_en;

  eck_pkg::cfg_t     cfg;
  eck_pkg::alu_req_t alu_req;
  eck_pkg::alu_rsp_t alu_rsp;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_bind_q      <= DataW'(16777216);
      rate_unbind_q    <= '0;
      rate_catalysis_q <= '0;
      time_step_q      <= DataW'(16777);
      mode_q           <= eck_pkg::ModeMassAction;
      init_complex_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        eck_pkg::RegRateBind:      rate_bind_q      <= pwdata[DataW-1:0];
        eck_pkg::RegRateUnbind:    rate_unbind_q    <= pwdata[DataW-1:0];
        eck_pkg::RegRateCatalysis: rate_catalysis_q <= pwdata[DataW-1:0];
        eck_pkg::RegTimeStep:      time_step_q      <= pwdata[DataW-1:0];
        eck_pkg::RegComplexMode:   mode_q           <= pwdata[1:0];
        eck_pkg::RegInitComplex:   init_complex_q   <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      eck_pkg::RegRateBind:      prdata = 64'(rate_bind_q);
      eck_pkg::RegRateUnbind:    prdata = 64'(rate_unbind_q);
      eck_pkg::RegRateCatalysis: prdata = 64'(rate_catalysis_q);
      eck_pkg::RegTimeStep:      prdata = 64'(time_step_q);
      eck_pkg::RegComplexMode:   prdata = 64'(mode_q);
      eck_pkg::RegInitComplex:   prdata = 64'(init_complex_q);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.rate_bind      = rate_bind_q;
  assign cfg.rate_unbind    = rate_unbind_q;
  assign cfg.rate_catalysis = rate_catalysis_q;
  assign cfg.time_step      = time_step_q;
  assign cfg.complex_mode   = mode_q;

  eck_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .alu_req_o (alu_req),
    .alu_rsp_i (alu_rsp)
  );

  eck_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for enzyme_complex_kinetics_step_top: directed and random ticks checked
// against an in-bench fixed-point kinetics predictor. Depends on eck_pkg, eck_in_if,
// eck_out_if and the top level RTL.
`default_nettype none

module tb_top;

  typedef logic [eck_pkg::DataW-1:0] q_t;

  typedef struct packed {
    q_t         enzyme;
    q_t         subst_a;
    q_t         subst_b;
    logic [1:0] n_subst;
    q_t         scale;
    q_t         vol;
    logic       prod;
  } tick_t;

  typedef struct packed {
    q_t unb;
    q_t bnd;
    q_t cat;
    q_t rel;
    q_t lvl;
    q_t conc;
  } kin_res_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel, penable, pwrite;
  logic [eck_pkg::CfgAddrW-1:0] paddr;
  logic [eck_pkg::CfgDataW-1:0] pwdata;
  logic [eck_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  eck_in_if  tick_ch ();
  eck_out_if res_ch ();

  enzyme_complex_kinetics_step_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tick_ch),
    .out_o   (res_ch)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of configuration and state
  q_t         k_bind, k_unbind, k_cat, dt_q;
  logic [1:0] kin_mode;
  q_t         cx_store;
  q_t         flux_hold [4];

  kin_res_t expected_q [$];
  int       n_fail;
  bit       calm;       // no idling on either side
  int       long_hold;  // receiver hold-off cycles left
  int       stall_left;

  // ---------------- fixed-point arithmetic ----------------
  function automatic q_t q_mul(q_t a, q_t b);
    logic [95:0] p;
    p = a * b;
    p = p >> eck_pkg::FracBits;
    return (p > eck_pkg::VMax) ? eck_pkg::VMax : p[eck_pkg::DataW-1:0];
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    logic [eck_pkg::DataW:0] s;
    s = a + b;
    return s[eck_pkg::DataW] ? eck_pkg::VMax : s[eck_pkg::DataW-1:0];
  endfunction

  function automatic q_t q_div(q_t a, q_t b);
    logic [71:0] n, q;
    if (b == '0) return eck_pkg::VMax;
    n = {a, 24'b0};
    q = n / b;
    return (q > eck_pkg::VMax) ? eck_pkg::VMax : q[eck_pkg::DataW-1:0];
  endfunction

  // exp(-x): range reduction, 12-term Taylor series at 48 fraction bits, squaring
  function automatic q_t exp_decay(q_t x);
    logic [63:0]  y, s, t;
    logic [127:0] w;
    int           k;
    k = 0;
    if (x >= eck_pkg::ExpLimit) return '0;
    y = 64'(x) << (eck_pkg::ExpBits - eck_pkg::FracBits);
    while (y > (64'd1 << (eck_pkg::ExpBits - 4))) begin
      y = y >> 1;
      k++;
    end
    s = 64'd1 << eck_pkg::ExpBits;
    t = s;
    for (int i = 1; i <= eck_pkg::TaylorTerms; i++) begin
      w = t * y;
      t = w[111:48] / i;
      if (i % 2 == 1) s = (s > t) ? s - t : 64'd0;
      else s = s + t;
    end
    for (int i = 0; i < k; i++) begin
      w = s * s;
      s = w[111:48];
    end
    s = s >> (eck_pkg::ExpBits - eck_pkg::FracBits);
    return s[eck_pkg::DataW-1:0];
  endfunction

  // one tick of the kinetics: updates the predictor state, returns the result
  function automatic kin_res_t step_kinetics(tick_t t);
    kin_res_t r;
    q_t c, fe, total, subs, km, rate, d, ratio, dec;
    q_t unb, bnd, cat, rel;
    c = cx_store;
    if (t.n_subst != 2'd0 && t.prod) begin
      fe = (t.scale != '0) ? q_div(t.enzyme, t.scale) : t.enzyme;
      subs = t.subst_a;
      if (t.n_subst >= 2'd2) subs = q_mul(subs, t.subst_b);
      if (kin_mode == eck_pkg::ModeMm) begin
        km = q_div(q_add(k_unbind, k_cat), k_bind);
        rate = q_div(q_mul(q_mul(subs, fe), k_cat), q_add(subs, km));
        unb = '0;
        bnd = rate;
        cat = rate;
        rel = '0;
        c = q_div(rate, k_cat);
      end else begin
        total = fe;
        if (kin_mode == eck_pkg::ModeLegacy) fe = (fe > c) ? fe - c : '0;
        unb = q_mul(k_unbind, c);
        bnd = q_mul(q_mul(subs, fe), k_bind);
        cat = q_mul(k_cat, c);
        rel = q_add(cat, unb);
        if (c != '0 && rel != '0) begin
          d = exp_decay(q_div(q_mul(rel, dt_q), c));
          ratio = q_div(bnd, rel);
          c = q_mul(c, q_add(d, q_mul(ratio, eck_pkg::QOne - d)));
        end else if (bnd >= rel) begin
          c = q_add(c, q_mul(bnd - rel, dt_q));
        end else begin
          dec = q_mul(rel - bnd, dt_q);
          c = (c > dec) ? c - dec : '0;
        end
        if (kin_mode == eck_pkg::ModeLegacy && c > total) c = total;
      end
      cx_store = c;
      flux_hold[0] = unb;
      flux_hold[1] = bnd;
      flux_hold[2] = cat;
      flux_hold[3] = rel;
    end
    r.unb  = flux_hold[0];
    r.bnd  = flux_hold[1];
    r.cat  = flux_hold[2];
    r.rel  = flux_hold[3];
    r.lvl  = cx_store;
    r.conc = q_div(cx_store, t.vol);
    return r;
  endfunction

  // ---------------- result checking ----------------
  function automatic void check_field(string name, q_t exp_v, q_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    kin_res_t e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, complex_level %h",
                 $time, res_ch.complex_level);
        n_fail++;
      end else begin
        e = expected_q.pop_front();
        check_field("unbind_flux", e.unb, res_ch.unbind_flux);
        check_field("bind_flux", e.bnd, res_ch.bind_flux);
        check_field("product_flux", e.cat, res_ch.product_flux);
        check_field("release_flux", e.rel, res_ch.release_flux);
        check_field("complex_level", e.lvl, res_ch.complex_level);
        check_field("complex_conc", e.conc, res_ch.complex_conc);
      end
    end
  end

  // receiver: random stall bursts, long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold > 0) begin
        long_hold--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- drivers ----------------
  // send one tick; valid stays high after acceptance until the next gap or drain
  task automatic send_tick(tick_t t);
    if (!calm && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    tick_ch.valid            <= 1'b1;
    tick_ch.enzyme_count     <= t.enzyme;
    tick_ch.substrate_first  <= t.subst_a;
    tick_ch.substrate_second <= t.subst_b;
    tick_ch.substrate_count  <= t.n_subst;
    tick_ch.intramol_scale   <= t.scale;
    tick_ch.volume           <= t.vol;
    tick_ch.product_present  <= t.prod;
    do @(posedge clk_i); while (!tick_ch.ready);
    expected_q.push_back(step_kinetics(t));
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write over APB, only with the block idle
  task automatic set_reg(logic [2:0] idx, q_t val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= eck_pkg::CfgAddrW'({idx, 3'b000});
    pwdata  <= eck_pkg::CfgDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      eck_pkg::RegRateBind:      k_bind = val;
      eck_pkg::RegRateUnbind:    k_unbind = val;
      eck_pkg::RegRateCatalysis: k_cat = val;
      eck_pkg::RegTimeStep:      dt_q = val;
      eck_pkg::RegComplexMode:   kin_mode = val[1:0];
      default: ;  // initial complex has no effect on the complex
    endcase
  endtask

  function automatic tick_t mk_tick(q_t e, q_t a, q_t b, logic [1:0] n, q_t sc, q_t v,
                                    logic p);
    tick_t t;
    t.enzyme = e; t.subst_a = a; t.subst_b = b; t.n_subst = n;
    t.scale = sc; t.vol = v; t.prod = p;
    return t;
  endfunction

  function automatic q_t rnd_q();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return eck_pkg::VMax;
      2:       return q_t'({$urandom, $urandom});
      3:       return q_t'($urandom_range(0, 32'h0400_0000));
      4:       return q_t'($urandom_range(0, 32'h0010_0000));
      default: return q_t'($urandom_range(0, 200)) << eck_pkg::FracBits;
    endcase
  endfunction

  // mostly moderate rates so the exponential path sees useful values
  function automatic q_t rnd_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return eck_pkg::VMax;
      2:       return q_t'({$urandom, $urandom});
      default: return q_t'($urandom_range(1, 32'h0300_0000));
    endcase
  endfunction

  function automatic tick_t rnd_tick();
    tick_t t;
    t.enzyme  = rnd_q();
    t.subst_a = rnd_q();
    t.subst_b = rnd_q();
    t.n_subst = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    t.scale   = ($urandom_range(0, 1) == 0) ? '0 : rnd_q();
    t.vol     = rnd_q();
    t.prod    = ($urandom_range(0, 9) != 0);
    return t;
  endfunction

  // ---------------- tests ----------------
  localparam q_t One  = eck_pkg::QOne;
  localparam q_t Half = eck_pkg::QOne >> 1;

  task automatic test_directed();
    // idle ticks: no substrate with zero volume, then no product pool
    send_tick(mk_tick(One, One, One, 2'd0, '0, '0, 1'b1));
    send_tick(mk_tick(One, One, One, 2'd1, '0, One, 1'b0));
    // reset rates: forward Euler growth from an empty complex
    send_tick(mk_tick(One, 2 * One, '0, 2'd1, '0, One, 1'b1));
    send_tick(mk_tick(4 * One, 3 * One, Half, 2'd2, '0, Half, 1'b1));
    // exponential update, two and three substrates, intramolecular scale
    set_reg(eck_pkg::RegRateUnbind, Half);
    set_reg(eck_pkg::RegRateCatalysis, One >> 2);
    set_reg(eck_pkg::RegTimeStep, One / 10);
    send_tick(mk_tick(10 * One, One, 2 * One, 2'd2, '0, One, 1'b1));
    send_tick(mk_tick(10 * One, One, 2 * One, 2'd3, 2 * One, One, 1'b1));
    send_tick(mk_tick(10 * One, 5 * One, One, 2'd1, eck_pkg::VMax, 3 * One, 1'b1));
    // large dt drives the exponent past its limit
    set_reg(eck_pkg::RegTimeStep, eck_pkg::VMax);
    send_tick(mk_tick(One, One, One, 2'd1, '0, One, 1'b1));
    // no binding: complex decays
    set_reg(eck_pkg::RegRateBind, '0);
    set_reg(eck_pkg::RegTimeStep, One);
    send_tick(mk_tick(One, One, One, 2'd1, '0, One, 1'b1));
    send_tick(mk_tick('0, '0, '0, 2'd1, '0, One, 1'b1));
    // legacy mode: complex taken from free enzyme, capped at enzyme count
    set_reg(eck_pkg::RegRateBind, One);
    set_reg(eck_pkg::RegComplexMode, eck_pkg::ModeLegacy);
    send_tick(mk_tick(Half, 8 * One, One, 2'd1, '0, One, 1'b1));
    send_tick(mk_tick(eck_pkg::VMax, eck_pkg::VMax, eck_pkg::VMax, 2'd2, '0,
                      eck_pkg::VMax, 1'b1));
    send_tick(mk_tick(One, One, One, 2'd1, '0, One, 1'b1));
    // Michaelis-Menten mode, including no catalysis and no binding
    set_reg(eck_pkg::RegComplexMode, eck_pkg::ModeMm);
    send_tick(mk_tick(10 * One, 3 * One, One, 2'd1, '0, 2 * One, 1'b1));
    send_tick(mk_tick(eck_pkg::VMax, eck_pkg::VMax, eck_pkg::VMax, 2'd3, eck_pkg::VMax,
                      eck_pkg::VMax, 1'b1));
    send_tick(mk_tick(One, One, One, 2'd0, '0, One, 1'b1));
    set_reg(eck_pkg::RegRateCatalysis, '0);
    send_tick(mk_tick(10 * One, 3 * One, One, 2'd1, '0, One, 1'b1));
    set_reg(eck_pkg::RegRateCatalysis, One);
    set_reg(eck_pkg::RegRateBind, '0);
    send_tick(mk_tick(10 * One, 3 * One, One, 2'd1, '0, One, 1'b1));
    // mode three behaves as mass action
    set_reg(eck_pkg::RegRateBind, One);
    set_reg(eck_pkg::RegComplexMode, 2'd3);
    send_tick(mk_tick(5 * One, One, One, 2'd1, '0, One, 1'b1));
    send_tick(mk_tick('0, '0, '0, 2'd2, '0, '0, 1'b1));
    set_reg(eck_pkg::RegInitComplex, eck_pkg::VMax);
    drain();
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    long_hold = 3000;
    for (int i = 0; i < 6; i++) send_tick(rnd_tick());
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == phases - 1) calm = 1'b1;
      set_reg(eck_pkg::RegRateBind, rnd_rate());
      set_reg(eck_pkg::RegRateUnbind, rnd_rate());
      set_reg(eck_pkg::RegRateCatalysis, rnd_rate());
      set_reg(eck_pkg::RegTimeStep, ($urandom_range(0, 7) == 0) ? rnd_q() :
                                    q_t'($urandom_range(0, 32'h0200_0000)));
      set_reg(eck_pkg::RegComplexMode, (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3)));
      set_reg(eck_pkg::RegInitComplex, rnd_q());
      for (int i = 0; i < per_phase; i++) send_tick(rnd_tick());
    end
    drain();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.enzyme_count     <= '0;
    tick_ch.substrate_first  <= '0;
    tick_ch.substrate_second <= '0;
    tick_ch.substrate_count  <= '0;
    tick_ch.intramol_scale   <= '0;
    tick_ch.volume           <= '0;
    tick_ch.product_present  <= 1'b0;
    n_fail     = 0;
    calm       = 1'b0;
    long_hold  = 0;
    stall_left = 0;
    // reset values of the predictor
    k_bind    = eck_pkg::QOne;
    k_unbind  = '0;
    k_cat     = '0;
    dt_q      = q_t'(16777);
    kin_mode  = eck_pkg::ModeMassAction;
    cx_store  = '0;
    for (int i = 0; i < 4; i++) flux_hold[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(9, 148);

    drain();
    repeat (1200) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("enzyme_complex_kinetics_step_top test passed");
    end else begin
      $display("enzyme_complex_kinetics_step_top test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #80000000;
    $display("enzyme_complex_kinetics_step_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
